@@ design/sbcr_pkg.sv @@
// Package for the swept box collision resolver: coordinate type, commands, beat types, arithmetic.
`timescale 1ns / 1ps
package sbcr_pkg;

	// Coordinates are signed Q16.16
	localparam int COORD_W = 32;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef enum logic [1:0] {
		CMD_BOX    = 2'd0,
		CMD_OLD    = 2'd1,
		CMD_DES    = 2'd2,
		CMD_STATIC = 2'd3
	} cmd_e;

	typedef struct packed {
		cmd_e   command;
		coord_t box_min_x;
		coord_t box_min_y;
		coord_t box_min_z;
		coord_t box_max_x;
		coord_t box_max_y;
		coord_t box_max_z;
		coord_t pos_x;
		coord_t pos_y;
		coord_t pos_z;
	} in_item_t;

	typedef struct packed {
		logic   hit;
		coord_t adjusted_x;
		coord_t adjusted_y;
		coord_t adjusted_z;
		logic   stop_x;
		logic   stop_y;
		logic   stop_z;
		logic   ground_contact;
	} out_item_t;

	// Accumulated resolve state, one entry per axis (0 X, 1 Y, 2 Z)
	typedef struct packed {
		logic [2:0][COORD_W-1:0] adj;
		logic [2:0]              stop;
		logic                    ground;
	} track_t;

	// Saturating add
	function automatic coord_t sat_add(coord_t a, coord_t b);
		logic signed [COORD_W:0] s;
		s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
		if (s[COORD_W] != s[COORD_W-1])
			return s[COORD_W] ? COORD_MIN : COORD_MAX;
		return coord_t'(s[COORD_W-1:0]);
	endfunction

	// Saturating subtract
	function automatic coord_t sat_sub(coord_t a, coord_t b);
		logic signed [COORD_W:0] s;
		s = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		if (s[COORD_W] != s[COORD_W-1])
			return s[COORD_W] ? COORD_MIN : COORD_MAX;
		return coord_t'(s[COORD_W-1:0]);
	endfunction

	// Signed a <= b
	function automatic logic le(coord_t a, coord_t b);
		return $signed(a) <= $signed(b);
	endfunction

endpackage

@@ design/sbcr_in_if.sv @@
// Input channel interface: valid/ready handshake carrying one command beat.
`timescale 1ns / 1ps
interface sbcr_in_if import sbcr_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/sbcr_out_if.sv @@
// Result channel interface: valid/ready handshake carrying one resolve result beat.
`timescale 1ns / 1ps
interface sbcr_out_if import sbcr_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/sbcr_resolve.sv @@
// Static box test against the swept box and gap accumulation into the adjusted location.
`timescale 1ns / 1ps
module sbcr_resolve import sbcr_pkg::*; (
	input  coord_t st_lo [3],
	input  coord_t st_hi [3],
	input  coord_t st_pos [3],
	input  coord_t swept_lo [3],
	input  coord_t swept_hi [3],
	input  coord_t des_lo [3],
	input  coord_t des_hi [3],
	input  track_t cur,
	output logic   hit,
	output track_t nxt
);

	coord_t     sw_lo [3];
	coord_t     sw_hi [3];
	coord_t     lo_gap [3];
	coord_t     hi_gap [3];
	coord_t     acc_lo [3];
	coord_t     acc_hi [3];
	logic [2:0] ov;

	// Static world box, overlap per axis and gap terms
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sw_lo[i]  = sat_add(st_lo[i], st_pos[i]);
			sw_hi[i]  = sat_add(st_hi[i], st_pos[i]);
			ov[i]     = le(swept_lo[i], sw_hi[i]) && le(sw_lo[i], swept_hi[i]);
			lo_gap[i] = sat_sub(sw_lo[i], des_hi[i]);
			hi_gap[i] = sat_sub(des_lo[i], sw_hi[i]);
		end
	end

	assign hit = &ov;

	// Lower term first, then upper term, each only when not negative
	always_comb begin
		nxt = cur;
		for (int i = 0; i < 3; i++) begin
			acc_lo[i] = coord_t'(cur.adj[i]);
			if (hit && !lo_gap[i][COORD_W-1]) begin
				acc_lo[i]   = sat_add(acc_lo[i], lo_gap[i]);
				nxt.stop[i] = 1'b1;
			end
			acc_hi[i] = acc_lo[i];
			if (hit && !hi_gap[i][COORD_W-1]) begin
				acc_hi[i]   = sat_add(acc_hi[i], hi_gap[i]);
				nxt.stop[i] = 1'b1;
				if (i == 2)
					nxt.ground = 1'b1;
			end
			nxt.adj[i] = acc_hi[i];
		end
	end

endmodule

@@ design/swept_box_collision_resolve.sv @@
// Top level of the swept box collision resolver.
`timescale 1ns / 1ps
// Resolves one moving box against a stream of static boxes in 3-D, Q16.16 with saturating
// sums. Beats with command load box, load old location or load desired location update the
// mover and reset the adjusted location and sticky flags; they produce no result. Each
// static beat produces exactly one result beat carrying the hit flag, the adjusted location
// after that beat and the sticky stop and ground flags. One beat is taken every cycle while the
// input is not stalled; a beat passes the input register, then the resolve logic into the
// result register, which presents its result. The rate is set by the adjusted-location
// accumulator, which is updated in the single resolve stage so the next static beat sees it
// at once. Back-pressure on the result channel stalls the input only when both registers
// are full.
module swept_box_collision_resolve import sbcr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sbcr_in_if.sink     item,
	sbcr_out_if.source  result
);

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t result_q;
	logic      res_valid_q;

	coord_t    mover_lo_q [3];
	coord_t    mover_hi_q [3];
	coord_t    old_loc_q [3];
	coord_t    des_loc_q [3];
	coord_t    des_lo_q [3];
	coord_t    des_hi_q [3];
	coord_t    swept_lo_q [3];
	coord_t    swept_hi_q [3];
	track_t    track_q;

	coord_t    st_lo [3];
	coord_t    st_hi [3];
	coord_t    st_pos [3];
	coord_t    nx_mover_lo [3];
	coord_t    nx_mover_hi [3];
	coord_t    nx_old [3];
	coord_t    nx_des [3];
	coord_t    o_lo [3];
	coord_t    o_hi [3];
	coord_t    d_lo [3];
	coord_t    d_hi [3];
	logic      hit;
	track_t    track_nxt;
	logic      is_static;
	logic      res_free;
	logic      retire;
	logic      load_go;
	logic      static_go;

	// Stage 1 item fields as axis arrays
	assign st_lo  = '{item_s1.box_min_x, item_s1.box_min_y, item_s1.box_min_z};
	assign st_hi  = '{item_s1.box_max_x, item_s1.box_max_y, item_s1.box_max_z};
	assign st_pos = '{item_s1.pos_x, item_s1.pos_y, item_s1.pos_z};

	// Flow control
	assign is_static  = (item_s1.command == CMD_STATIC);
	assign res_free   = !res_valid_q || result.ready;
	assign retire     = valid_s1 && (!is_static || res_free);
	assign load_go    = retire && !is_static;
	assign static_go  = retire && is_static;
	assign item.ready = !valid_s1 || retire;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid)
			item_s1 <= item.data;
	end

	// Mover update on load beats: desired and swept world boxes
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nx_mover_lo[i] = (item_s1.command == CMD_BOX) ? st_lo[i] : mover_lo_q[i];
			nx_mover_hi[i] = (item_s1.command == CMD_BOX) ? st_hi[i] : mover_hi_q[i];
			nx_old[i]      = (item_s1.command == CMD_OLD) ? st_pos[i] : old_loc_q[i];
			nx_des[i]      = (item_s1.command == CMD_DES) ? st_pos[i] : des_loc_q[i];
			o_lo[i]        = sat_add(nx_mover_lo[i], nx_old[i]);
			o_hi[i]        = sat_add(nx_mover_hi[i], nx_old[i]);
			d_lo[i]        = sat_add(nx_mover_lo[i], nx_des[i]);
			d_hi[i]        = sat_add(nx_mover_hi[i], nx_des[i]);
		end
	end

	// Static beat resolve
	sbcr_resolve u_resolve (
		.st_lo    (st_lo),
		.st_hi    (st_hi),
		.st_pos   (st_pos),
		.swept_lo (swept_lo_q),
		.swept_hi (swept_hi_q),
		.des_lo   (des_lo_q),
		.des_hi   (des_hi_q),
		.cur      (track_q),
		.hit      (hit),
		.nxt      (track_nxt)
	);

	// Mover state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				mover_lo_q[i] <= '0;
				mover_hi_q[i] <= '0;
				old_loc_q[i]  <= '0;
				des_loc_q[i]  <= '0;
				des_lo_q[i]   <= '0;
				des_hi_q[i]   <= '0;
				swept_lo_q[i] <= '0;
				swept_hi_q[i] <= '0;
			end
		end else if (load_go) begin
			for (int i = 0; i < 3; i++) begin
				mover_lo_q[i] <= nx_mover_lo[i];
				mover_hi_q[i] <= nx_mover_hi[i];
				old_loc_q[i]  <= nx_old[i];
				des_loc_q[i]  <= nx_des[i];
				des_lo_q[i]   <= d_lo[i];
				des_hi_q[i]   <= d_hi[i];
				swept_lo_q[i] <= le(o_lo[i], d_lo[i]) ? o_lo[i] : d_lo[i];
				swept_hi_q[i] <= le(o_hi[i], d_hi[i]) ? d_hi[i] : o_hi[i];
			end
		end
	end

	// Adjusted location and sticky flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_q <= '0;
		end else if (load_go) begin
			for (int i = 0; i < 3; i++)
				track_q.adj[i] <= nx_des[i];
			track_q.stop   <= '0;
			track_q.ground <= 1'b0;
		end else if (static_go) begin
			track_q <= track_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_free) begin
			res_valid_q <= static_go;
		end
	end

	always_ff @(posedge clk) begin
		if (static_go) begin
			result_q.hit            <= hit;
			result_q.adjusted_x     <= coord_t'(track_nxt.adj[0]);
			result_q.adjusted_y     <= coord_t'(track_nxt.adj[1]);
			result_q.adjusted_z     <= coord_t'(track_nxt.adj[2]);
			result_q.stop_x         <= track_nxt.stop[0];
			result_q.stop_y         <= track_nxt.stop[1];
			result_q.stop_z         <= track_nxt.stop[2];
			result_q.ground_contact <= track_nxt.ground;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = result_q;

	// Ground contact only comes with a Z stop
	a_ground_implies_stop_z: assert property (@(posedge clk) disable iff (!arst_n)
		track_q.ground |-> track_q.stop[2])
		else $error("ground flag set without Z stop");

	// A load clears the sticky flags
	a_load_clears_flags: assert property (@(posedge clk) disable iff (!arst_n)
		load_go |=> (track_q.stop == 3'b000) && !track_q.ground)
		else $error("sticky flags not cleared by load");

	// A load restarts the adjusted location from the desired location
	a_load_sets_adjusted: assert property (@(posedge clk) disable iff (!arst_n)
		load_go |=> (coord_t'(track_q.adj[0]) == des_loc_q[0])
			&& (coord_t'(track_q.adj[1]) == des_loc_q[1])
			&& (coord_t'(track_q.adj[2]) == des_loc_q[2]))
		else $error("adjusted location not reloaded");

	// The swept box always encloses the desired box
	a_swept_encloses: assert property (@(posedge clk) disable iff (!arst_n)
		le(swept_lo_q[0], des_lo_q[0]) && le(swept_lo_q[1], des_lo_q[1])
			&& le(swept_lo_q[2], des_lo_q[2]) && le(des_hi_q[0], swept_hi_q[0])
			&& le(des_hi_q[1], swept_hi_q[1]) && le(des_hi_q[2], swept_hi_q[2]))
		else $error("swept box does not enclose desired box");

	// Input stalls only behind a static beat blocked by a full result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> valid_s1 && is_static && res_valid_q && !result.ready)
		else $error("input stalled without cause");

endmodule

@@ tb/sv/sbcr_resolve_check.sv @@
// Result checker for the swept box resolver: tracks the mover state and compares every result.
`timescale 1ns / 1ps
module sbcr_resolve_check import sbcr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	sbcr_in_if   item,
	sbcr_out_if  result,
	output int   mismatches,
	output int   awaiting
);

	// Mover state; box index 0..2 is min X/Y/Z, 3..5 is max X/Y/Z
	coord_t mover_box [6];
	coord_t old_loc [3];
	coord_t des_loc [3];
	coord_t des_box [6];
	coord_t swept_box [6];
	coord_t adjusted [3];
	logic [2:0] stop_bits;
	logic       ground;

	out_item_t expected_results [$];
	int        results_seen;

	// Clamp a wide sum to the coordinate range
	function automatic coord_t clamp_sum(longint s);
		if (s > longint'(COORD_MAX))
			return COORD_MAX;
		if (s < longint'(COORD_MIN))
			return COORD_MIN;
		return coord_t'(s);
	endfunction

	function automatic coord_t sat_plus(coord_t a, coord_t b);
		return clamp_sum(longint'(a) + longint'(b));
	endfunction

	function automatic coord_t sat_minus(coord_t a, coord_t b);
		return clamp_sum(longint'(a) - longint'(b));
	endfunction

	// Any load rebuilds the desired and swept world boxes and restarts the accumulation
	function automatic void refresh_mover();
		coord_t from_old, to_des;
		for (int i = 0; i < 6; i++) begin
			from_old   = sat_plus(mover_box[i], old_loc[i % 3]);
			to_des     = sat_plus(mover_box[i], des_loc[i % 3]);
			des_box[i] = to_des;
			if (i < 3)
				swept_box[i] = (from_old < to_des) ? from_old : to_des;
			else
				swept_box[i] = (from_old > to_des) ? from_old : to_des;
		end
		for (int a = 0; a < 3; a++)
			adjusted[a] = des_loc[a];
		stop_bits = '0;
		ground    = 1'b0;
	endfunction

	// Update the mover on a load beat; queue the expected result on a static beat
	function automatic void apply_beat(in_item_t b);
		coord_t    lbox [6];
		coord_t    at [3];
		coord_t    st [6];
		coord_t    lo_gap, hi_gap;
		logic      touched;
		out_item_t r;
		lbox = '{b.box_min_x, b.box_min_y, b.box_min_z, b.box_max_x, b.box_max_y, b.box_max_z};
		at   = '{b.pos_x, b.pos_y, b.pos_z};
		case (b.command)
			CMD_BOX: begin
				mover_box = lbox;
				refresh_mover();
			end
			CMD_OLD: begin
				old_loc = at;
				refresh_mover();
			end
			CMD_DES: begin
				des_loc = at;
				refresh_mover();
			end
			default: begin
				for (int i = 0; i < 6; i++)
					st[i] = sat_plus(lbox[i], at[i % 3]);
				// overlap is inclusive on every face
				touched = 1'b1;
				for (int a = 0; a < 3; a++)
					if (!(swept_box[a] <= st[3 + a] && swept_box[3 + a] >= st[a]))
						touched = 1'b0;
				// gaps always come from the unadjusted desired box
				if (touched) begin
					for (int a = 0; a < 3; a++) begin
						lo_gap = sat_minus(st[a], des_box[3 + a]);
						hi_gap = sat_minus(des_box[a], st[3 + a]);
						if (lo_gap >= 0) begin
							adjusted[a]  = sat_plus(adjusted[a], lo_gap);
							stop_bits[a] = 1'b1;
						end
						if (hi_gap >= 0) begin
							adjusted[a]  = sat_plus(adjusted[a], hi_gap);
							stop_bits[a] = 1'b1;
							if (a == 2)
								ground = 1'b1;
						end
					end
				end
				r.hit            = touched;
				r.adjusted_x     = adjusted[0];
				r.adjusted_y     = adjusted[1];
				r.adjusted_z     = adjusted[2];
				r.stop_x         = stop_bits[0];
				r.stop_y         = stop_bits[1];
				r.stop_z         = stop_bits[2];
				r.ground_contact = ground;
				expected_results.insert(expected_results.size(), r);
			end
		endcase
	endfunction

	task automatic report_mismatch(string what);
		if (mismatches < 50)
			$display("%0t resolve_check: result %0d: %s", $time, results_seen, what);
		mismatches++;
	endtask

	// Compare first: a result never belongs to the beat taken on the same edge
	always @(posedge clk or negedge arst_n) begin
		out_item_t want, got;
		if (!arst_n) begin
			mover_box  = '{default: '0};
			old_loc    = '{default: '0};
			des_loc    = '{default: '0};
			des_box    = '{default: '0};
			swept_box  = '{default: '0};
			adjusted   = '{default: '0};
			stop_bits  = '0;
			ground     = 1'b0;
			expected_results.delete();
			results_seen = 0;
			mismatches   = 0;
			awaiting     = 0;
		end else begin
			if (result.valid && result.ready) begin
				got = result.data;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("beat with nothing expected, hit %0b", got.hit));
				end else begin
					want = expected_results.pop_front();
					if (got.hit !== want.hit)
						report_mismatch($sformatf("hit %0b, want %0b", got.hit, want.hit));
					if (got.adjusted_x !== want.adjusted_x)
						report_mismatch($sformatf("adjusted_x %0d, want %0d",
							got.adjusted_x, want.adjusted_x));
					if (got.adjusted_y !== want.adjusted_y)
						report_mismatch($sformatf("adjusted_y %0d, want %0d",
							got.adjusted_y, want.adjusted_y));
					if (got.adjusted_z !== want.adjusted_z)
						report_mismatch($sformatf("adjusted_z %0d, want %0d",
							got.adjusted_z, want.adjusted_z));
					if (got.stop_x !== want.stop_x)
						report_mismatch($sformatf("stop_x %0b, want %0b", got.stop_x, want.stop_x));
					if (got.stop_y !== want.stop_y)
						report_mismatch($sformatf("stop_y %0b, want %0b", got.stop_y, want.stop_y));
					if (got.stop_z !== want.stop_z)
						report_mismatch($sformatf("stop_z %0b, want %0b", got.stop_z, want.stop_z));
					if (got.ground_contact !== want.ground_contact)
						report_mismatch($sformatf("ground_contact %0b, want %0b",
							got.ground_contact, want.ground_contact));
				end
				results_seen++;
			end
			if (item.valid && item.ready)
				apply_beat(item.data);
			awaiting = expected_results.size();
		end
	end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the swept box resolver: clock, reset, command stimulus, backpressure, verdict.
`timescale 1ns / 1ps
module tb import sbcr_pkg::*; ();

	localparam int          U            = 1 << 16;   // one unit in Q16.16
	localparam int          RANDOM_BEATS = 1750;
	localparam int          HOLD_CYCLES  = 80;
	localparam int          DRAIN_CYCLES = 10;
	localparam int unsigned CYCLE_LIMIT  = 200000;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} xyz_t;

	logic clk;
	logic arst_n;
	sbcr_in_if  item ();
	sbcr_out_if result ();

	int          mismatches;
	int          awaiting;
	int          beats_sent    = 0;
	int          src_idle_pct  = 11;
	int          sink_idle_pct = 87;
	int          hold_requests = 0;
	int          holds_served  = 0;
	int unsigned cycles        = 0;

	swept_box_collision_resolve dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result)
	);

	sbcr_resolve_check resolve_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.result     (result),
		.mismatches (mismatches),
		.awaiting   (awaiting)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested
	initial begin
		int stall_left;
		stall_left = 0;
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0 && holds_served != hold_requests) begin
				stall_left = HOLD_CYCLES;
				holds_served++;
			end
			if (stall_left > 0) begin
				result.ready <= 1'b0;
				stall_left--;
			end else begin
				result.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Random Q16.16 value from lo_u units up to just below hi_u + 1 units, half the time on the unit grid
	function automatic coord_t span(int lo_u, int hi_u);
		int whole;
		whole = int'($urandom_range(hi_u - lo_u)) + lo_u;
		return coord_t'(whole * U + ($urandom_range(1) ? int'($urandom_range(U - 1)) : 0));
	endfunction

	function automatic coord_t wild();
		case ($urandom_range(7))
			0:       return COORD_MAX;
			1:       return COORD_MIN;
			2, 3, 4: return coord_t'($urandom);
			default: return span(-200, 200);
		endcase
	endfunction

	function automatic xyz_t wild3();
		return '{wild(), wild(), wild()};
	endfunction

	function automatic coord_t rim_coord();
		return $urandom_range(1) ? coord_t'(COORD_MAX - 8 * U) : coord_t'(COORD_MIN + 8 * U);
	endfunction

	function automatic xyz_t near(xyz_t c, int spread);
		return '{coord_t'(c.x + span(-spread, spread)), coord_t'(c.y + span(-spread, spread)),
			coord_t'(c.z + span(-spread, spread))};
	endfunction

	function automatic in_item_t beat_of(cmd_e c, xyz_t lo, xyz_t hi, xyz_t at);
		in_item_t b;
		b.command   = c;
		b.box_min_x = lo.x;
		b.box_min_y = lo.y;
		b.box_min_z = lo.z;
		b.box_max_x = hi.x;
		b.box_max_y = hi.y;
		b.box_max_z = hi.z;
		b.pos_x     = at.x;
		b.pos_y     = at.y;
		b.pos_z     = at.z;
		return b;
	endfunction

	function automatic in_item_t noise_beat();
		return beat_of(cmd_e'($urandom_range(3)), wild3(), wild3(), wild3());
	endfunction

	// One beat on the command channel, with random idle cycles ahead of it
	task automatic send_beat(input in_item_t b);
		while ($urandom_range(99) < src_idle_pct) begin
			item.valid <= 1'b0;
			@(posedge clk);
		end
		item.valid <= 1'b1;
		item.data  <= b;
		@(posedge clk);
		while (!item.ready)
			@(posedge clk);
		beats_sent++;
	endtask

	// A mover load followed by static boxes scattered around its path
	task automatic send_scene();
		xyz_t base, lo, hi, swap;
		int   statics;
		if ($urandom_range(9) == 0)
			base = '{rim_coord(), rim_coord(), rim_coord()};
		else
			base = '{span(-500, 500), span(-500, 500), span(-500, 500)};
		lo = '{-span(0, 3), -span(0, 3), -span(0, 3)};
		hi = '{span(0, 3), span(0, 3), span(0, 3)};
		// occasionally an inverted mover box
		if ($urandom_range(9) == 0) begin
			swap = lo;
			lo   = hi;
			hi   = swap;
		end
		if ($urandom_range(4) != 0) begin
			send_beat(beat_of(CMD_BOX, lo, hi, wild3()));
			send_beat(beat_of(CMD_OLD, wild3(), wild3(), near(base, 6)));
			send_beat(beat_of(CMD_DES, wild3(), wild3(), near(base, 6)));
		end else begin
			// partial or reordered reload
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(2))
					0:       send_beat(beat_of(CMD_BOX, lo, hi, wild3()));
					1:       send_beat(beat_of(CMD_OLD, wild3(), wild3(), near(base, 6)));
					default: send_beat(beat_of(CMD_DES, wild3(), wild3(), near(base, 6)));
				endcase
			end
		end
		statics = $urandom_range(2, 10);
		repeat (statics) begin
			if ($urandom_range(6) == 0)
				send_beat(noise_beat());
			else
				send_beat(beat_of(CMD_STATIC, '{-span(0, 3), -span(0, 3), -span(0, 3)},
					'{span(0, 3), span(0, 3), span(0, 3)}, near(base, 6)));
		end
	endtask

	// Stimulus and verdict
	initial begin
		xyz_t zero3, top3, bot3;
		int   target;
		zero3 = '0;
		top3  = '{COORD_MAX, COORD_MAX, COORD_MAX};
		bot3  = '{COORD_MIN, COORD_MIN, COORD_MIN};
		arst_n     <= 1'b0;
		item.valid <= 1'b0;
		item.data  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Statics against the reset state: a point mover at the origin
		send_beat(beat_of(CMD_STATIC, zero3, zero3, zero3));
		send_beat(beat_of(CMD_STATIC, '{-U, -U, -U}, '{U, U, U}, zero3));
		send_beat(beat_of(CMD_STATIC, top3, top3, top3));
		send_beat(beat_of(CMD_STATIC, bot3, bot3, bot3));
		// Falling mover: floor contact, wall in the path, clear miss
		send_beat(beat_of(CMD_BOX, '{-2 * U, -2 * U, -2 * U}, '{2 * U, 2 * U, 2 * U}, zero3));
		send_beat(beat_of(CMD_OLD, zero3, zero3, '{0, 0, 10 * U}));
		send_beat(beat_of(CMD_DES, zero3, zero3, zero3));
		send_beat(beat_of(CMD_STATIC, '{-5 * U, -5 * U, -4 * U}, '{5 * U, 5 * U, -2 * U}, zero3));
		send_beat(beat_of(CMD_STATIC, '{-U, -U, 4 * U}, '{U, U, 6 * U}, zero3));
		send_beat(beat_of(CMD_STATIC, '{3 * U, -U, -U}, '{4 * U, U, U}, zero3));
		// Extreme mover: the max corner plus the old location and the min corner plus the desired location saturate
		send_beat(beat_of(CMD_BOX, bot3, top3, zero3));
		send_beat(beat_of(CMD_OLD, zero3, zero3, top3));
		send_beat(beat_of(CMD_DES, zero3, zero3, bot3));
		send_beat(beat_of(CMD_STATIC, zero3, zero3, zero3));
		send_beat(beat_of(CMD_STATIC, top3, top3, top3));
		send_beat(beat_of(CMD_STATIC, bot3, bot3, bot3));
		// Inverted mover box
		send_beat(beat_of(CMD_BOX, '{3 * U, 3 * U, 3 * U}, '{-3 * U, -3 * U, -3 * U}, zero3));
		send_beat(beat_of(CMD_OLD, zero3, zero3, '{U, 2 * U, 3 * U}));
		send_beat(beat_of(CMD_DES, zero3, zero3, '{-U, -2 * U, -3 * U}));
		send_beat(beat_of(CMD_STATIC, '{-2 * U, -2 * U, -2 * U}, '{2 * U, 2 * U, 2 * U}, zero3));
		// Point mover swept across the whole range: adjusted location saturates
		send_beat(beat_of(CMD_BOX, zero3, zero3, zero3));
		send_beat(beat_of(CMD_OLD, zero3, zero3, bot3));
		send_beat(beat_of(CMD_DES, zero3, zero3, top3));
		send_beat(beat_of(CMD_STATIC, bot3, bot3, zero3));
		send_beat(beat_of(CMD_STATIC, bot3, bot3, zero3));

		// Random scenes in three idling phases; the last one opens with a long hold-off
		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct  = (phase == 0) ? 11 : (phase == 1) ? 87 : 0;
			sink_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 11 : 0;
			if (phase == 2)
				hold_requests++;
			target = beats_sent + RANDOM_BEATS / 3;
			while (beats_sent < target)
				send_scene();
		end

		item.valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaiting == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
